// ===== rtl/i2c_master_byte_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the I2C master byte engine
// Shared shorthand for the concurrent checks on the engine ports.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during rst
`define I2CMBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled during rst
`define I2CMBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Transaction types, operation codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  // Operation codes carried in the input transaction
  localparam logic [2:0] OP_START    = 3'd0;
  localparam logic [2:0] OP_STOP     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_READ     = 3'd3;
  localparam logic [2:0] OP_WAIT_ACK = 3'd4;
  localparam logic [2:0] OP_ACK      = 3'd5;
  localparam logic [2:0] OP_NACK     = 3'd6;
  localparam logic [2:0] OP_INVALID  = 3'd7;

  // Configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TIMEOUT = 1'b1;

  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RESET = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] ACK_TIMEOUT_RESET = 16'd60000;

  localparam int BITS_PER_BYTE = 8;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
    logic       ack_timed_out;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_byte_engine_core.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine core
// Each accepted tick transaction has its result registered and offered in the next cycle.
// Throughput: one tick per cycle while the result is not stalled; the phase
// update is a single pass of logic between the state and result registers.
// Reset (rst, synchronous): idle, SCL and SDA released, registers to defaults.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  i2cmbe_pkg::in_item_t               in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output i2cmbe_pkg::out_item_t              out_data,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [i2cmbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2cmbe_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] half_period_ticks;
  logic [CFG_DATA_W-1:0] ack_timeout_ticks;

  // Engine state
  logic [2:0]  current_op,  current_op_next;
  logic        busy_flag,   busy_flag_next;
  logic [2:0]  phase_step,  phase_step_next;
  logic [3:0]  bit_count,   bit_count_next;
  logic [7:0]  shift_reg,   shift_reg_next;
  logic [15:0] delay_count, delay_count_next;
  logic [15:0] poll_count,  poll_count_next;
  logic        scl_level,   scl_level_next;
  logic        sda_level,   sda_level_next;
  logic [7:0]  read_byte,   read_byte_next;
  logic        ack_flag,    ack_flag_next;
  logic        timeout_flag, timeout_flag_next;
  logic        done_next;

  logic        in_accept;
  logic        do_enter;
  logic        finished;
  logic        poll_end;
  logic [15:0] delay_load;

  // Hold the input while the result register is full and stalled
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign delay_load = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
      ack_timeout_ticks <= ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the engine by one tick
  always_comb begin
    current_op_next   = current_op;
    busy_flag_next    = busy_flag;
    phase_step_next   = phase_step;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    delay_count_next  = delay_count;
    poll_count_next   = poll_count;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    read_byte_next    = read_byte;
    ack_flag_next     = ack_flag;
    timeout_flag_next = timeout_flag;
    done_next         = 1'b0;
    do_enter          = 1'b0;
    finished          = 1'b0;
    poll_end          = 1'b0;

    if (!busy_flag) begin
      // Launch a new command
      if (in_data.cmd_valid && (in_data.operation != OP_INVALID)) begin
        current_op_next = in_data.operation;
        busy_flag_next  = 1'b1;
        phase_step_next = 3'd0;
        bit_count_next  = 4'd0;
        if (in_data.operation == OP_WRITE) begin
          shift_reg_next = in_data.write_data;
        end
        if (in_data.operation == OP_READ) begin
          shift_reg_next = 8'd0;
          sda_level_next = 1'b1;
        end
        if (in_data.operation == OP_WAIT_ACK) begin
          ack_flag_next     = 1'b0;
          timeout_flag_next = 1'b0;
        end
        do_enter = 1'b1;
      end
    end else if ((current_op == OP_WAIT_ACK) && (phase_step == 3'd1)) begin
      // Poll SDA for the acknowledge
      if (!in_data.sda_in) begin
        ack_flag_next = 1'b1;
        poll_end      = 1'b1;
      end else if (poll_count >= ack_timeout_ticks) begin
        timeout_flag_next = 1'b1;
        poll_end          = 1'b1;
      end else begin
        poll_count_next = poll_count + 16'd1;
      end
      if (poll_end) begin
        phase_step_next = 3'd2;
        do_enter        = 1'b1;
      end
    end else if (delay_count > 16'd1) begin
      delay_count_next = delay_count - 16'd1;
    end else begin
      // Phase expired: pick the next phase or finish
      case (current_op)
        OP_WRITE: begin
          if (phase_step == 3'd2) begin
            shift_reg_next  = {shift_reg[6:0], 1'b0};
            bit_count_next  = bit_count + 4'd1;
            phase_step_next = (bit_count_next < 4'(BITS_PER_BYTE)) ? 3'd0 : 3'd3;
          end else if (phase_step == 3'd3) begin
            finished = 1'b1;
          end else begin
            phase_step_next = phase_step + 3'd1;
          end
        end
        OP_READ: begin
          if (phase_step == 3'd1) begin
            shift_reg_next = {shift_reg[6:0], in_data.sda_in};
            bit_count_next = bit_count + 4'd1;
            if (bit_count_next >= 4'(BITS_PER_BYTE)) begin
              read_byte_next = shift_reg_next;
              finished       = 1'b1;
            end else begin
              phase_step_next = 3'd0;
            end
          end else begin
            phase_step_next = 3'd1;
          end
        end
        OP_START, OP_STOP: begin
          if (phase_step >= 3'd2) begin
            finished = 1'b1;
          end else begin
            phase_step_next = phase_step + 3'd1;
          end
        end
        default: begin
          if (phase_step >= 3'd3) begin
            finished = 1'b1;
          end else begin
            phase_step_next = phase_step + 3'd1;
          end
        end
      endcase
      if (finished) begin
        busy_flag_next   = 1'b0;
        phase_step_next  = 3'd0;
        delay_count_next = 16'd0;
        done_next        = 1'b1;
      end else begin
        do_enter = 1'b1;
      end
    end

    // Drive the pins for the phase being entered and reload its timer
    if (do_enter) begin
      case (current_op_next)
        OP_START: begin
          if (phase_step_next == 3'd0) begin
            sda_level_next = 1'b1;
            scl_level_next = 1'b1;
          end else if (phase_step_next == 3'd1) begin
            sda_level_next = 1'b0;
          end else begin
            scl_level_next = 1'b0;
          end
        end
        OP_STOP: begin
          if (phase_step_next == 3'd0) begin
            scl_level_next = 1'b0;
          end else if (phase_step_next == 3'd1) begin
            sda_level_next = 1'b0;
            scl_level_next = 1'b1;
          end else begin
            sda_level_next = 1'b1;
          end
        end
        OP_WRITE: begin
          if ((phase_step_next == 3'd0) || (phase_step_next == 3'd3)) begin
            scl_level_next = 1'b0;
          end else if (phase_step_next == 3'd1) begin
            sda_level_next = shift_reg_next[7];
          end else begin
            scl_level_next = 1'b1;
          end
        end
        OP_READ: begin
          scl_level_next = (phase_step_next != 3'd0);
        end
        OP_WAIT_ACK: begin
          if (phase_step_next == 3'd0) begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b1;
          end else if (phase_step_next == 3'd1) begin
            scl_level_next = 1'b1;
          end else if (phase_step_next == 3'd3) begin
            scl_level_next = 1'b0;
          end
        end
        default: begin
          if ((phase_step_next == 3'd0) || (phase_step_next == 3'd3)) begin
            scl_level_next = 1'b0;
          end else if (phase_step_next == 3'd1) begin
            sda_level_next = (current_op_next != OP_ACK);
          end else begin
            scl_level_next = 1'b1;
          end
        end
      endcase
      delay_count_next = delay_load;
      poll_count_next  = 16'd0;
    end
  end

  // Update state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      current_op   <= OP_START;
      busy_flag    <= 1'b0;
      phase_step   <= 3'd0;
      bit_count    <= 4'd0;
      shift_reg    <= 8'd0;
      delay_count  <= 16'd0;
      poll_count   <= 16'd0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      read_byte    <= 8'd0;
      ack_flag     <= 1'b0;
      timeout_flag <= 1'b0;
    end else if (in_accept) begin
      current_op   <= current_op_next;
      busy_flag    <= busy_flag_next;
      phase_step   <= phase_step_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      delay_count  <= delay_count_next;
      poll_count   <= poll_count_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      read_byte    <= read_byte_next;
      ack_flag     <= ack_flag_next;
      timeout_flag <= timeout_flag_next;
    end
  end

  // Track the result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.scl_out       <= scl_level_next;
      out_data.sda_out       <= sda_level_next;
      out_data.ready_res     <= ~busy_flag_next;
      out_data.done_res      <= done_next;
      out_data.read_data     <= read_byte_next;
      out_data.ack_received  <= ack_flag_next;
      out_data.ack_timed_out <= timeout_flag_next;
    end
  end

endmodule

// ===== rtl/i2cmbe_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master byte engine port checker
// Watches the engine ports over time and flags broken transactions.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_macros.svh"

module i2cmbe_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input i2cmbe_pkg::out_item_t out_data
);
  import i2cmbe_pkg::*;

  // Keep a stalled result on offer
  `I2CMBE_ASSERT_NEXT(a_out_valid_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // Produce a result for every accepted tick
  `I2CMBE_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid, "accepted tick gave no result")

  // Report completion only when the engine is idle again
  `I2CMBE_ASSERT_NOW(a_done_means_ready, out_valid && out_data.done_res, out_data.ready_res, "done without ready")

  // Never report ack and timeout together
  `I2CMBE_ASSERT_NOW(a_ack_xor_timeout, out_valid, !(out_data.ack_received && out_data.ack_timed_out), "ack and timeout both set")

endmodule

bind i2c_master_byte_engine_core i2cmbe_checker u_i2cmbe_checker (.*);
